### src/max_box_sum_2d_top_macros.svh
// Assertion macros shared by the checker of max_box_sum_2d_top.
// No dependencies.
`ifndef MAX_BOX_SUM_2D_TOP_MACROS_SVH
`define MAX_BOX_SUM_2D_TOP_MACROS_SVH

// Checked outside reset only.
`define MBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mbs_pkg.sv
// Package for max_box_sum_2d: sizes, register indexes, per-item control struct.
// No dependencies.
package mbs_pkg;

  localparam int MAX_COLS     = 1024;
  localparam int MAX_WIN_ROWS = 16;
  localparam int MAX_WIN_COLS = 16;

  localparam int SAMPLE_W = 16;
  localparam int FROWS_W  = 16;
  localparam int FCOLS_W  = 11;
  localparam int WIN_W    = 5;
  localparam int CFG_W    = 16;
  localparam int BEST_W   = 23;

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SLOT_W = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
  localparam int TAP_W  = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1;
  localparam int OS_W   = SLOT_W + 2;

  localparam int CS_W = SAMPLE_W + SLOT_W + 1;
  localparam int WS_W = CS_W + TAP_W - 1;

  localparam int LINE_DEPTH = 2 ** (SLOT_W + COL_W);

  typedef enum logic [1:0] {
    CFG_FRAME_ROWS = 2'd0,
    CFG_FRAME_COLS = 2'd1,
    CFG_WIN_ROWS   = 2'd2,
    CFG_WIN_COLS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             first_row;
    logic             sub_old;
    logic             win_ok;
    logic             col0;
    logic             sub_delay;
    logic             elig;
    logic             last;
    logic [TAP_W-1:0] tap;
  } mbs_flags_t;

endpackage

### src/max_box_sum_2d_top.sv
// Largest fixed-size window sum per frame over a row-major sample stream.
// The result register loads once a frame's last sample has passed the s1, s2 and s3 stages.
// Throughput: one sample per cycle; input stalls only while a frame result
// waits on out_ready and the next frame's result is ready to leave.
// Reset (rst_n low, synchronous): config back to 8 rows, 8 cols, 2x2 window;
// position, pipeline and best sum cleared. Line store needs no clearing.
module max_box_sum_2d_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mbs_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mbs_pkg::BEST_W-1:0]          out_best_sum,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [mbs_pkg::CFG_W-1:0]           cfg_data
);

  logic [mbs_pkg::FROWS_W-1:0] frame_rows_r;
  logic [mbs_pkg::FCOLS_W-1:0] frame_cols_r;
  logic [mbs_pkg::WIN_W-1:0]   window_rows_r;
  logic [mbs_pkg::WIN_W-1:0]   window_cols_r;

  logic [mbs_pkg::FROWS_W-1:0] row_r;
  logic [mbs_pkg::COL_W-1:0]   col_r;
  logic [mbs_pkg::SLOT_W-1:0]  slot_r;

  logic [mbs_pkg::FROWS_W-1:0] rows_eff;
  logic [mbs_pkg::FCOLS_W-1:0] cols_eff;
  logic [mbs_pkg::FROWS_W:0]   row_p1;
  logic [mbs_pkg::FCOLS_W-1:0] col_ext;
  logic [mbs_pkg::FCOLS_W-1:0] col_p1;
  logic                        win_ok;
  logic                        col_last;
  logic                        row_last;
  logic [mbs_pkg::OS_W-1:0]    old_sum;
  logic [mbs_pkg::SLOT_W-1:0]  rd_slot;
  mbs_pkg::mbs_flags_t         flags;

  logic                        adv;
  logic                        acc;
  logic                        s2_valid;
  mbs_pkg::mbs_flags_t         s2_flags;
  logic signed [mbs_pkg::CS_W-1:0] s2_cs;

  assign cfg_ready = 1'b1;
  assign in_ready  = adv;
  assign acc       = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r  <= mbs_pkg::FROWS_W'(8);
      frame_cols_r  <= mbs_pkg::FCOLS_W'(8);
      window_rows_r <= mbs_pkg::WIN_W'(2);
      window_cols_r <= mbs_pkg::WIN_W'(2);
    end else if (cfg_valid) begin
      unique case (mbs_pkg::cfg_idx_t'(cfg_index))
        mbs_pkg::CFG_FRAME_ROWS: frame_rows_r  <= cfg_data[mbs_pkg::FROWS_W-1:0];
        mbs_pkg::CFG_FRAME_COLS: frame_cols_r  <= cfg_data[mbs_pkg::FCOLS_W-1:0];
        mbs_pkg::CFG_WIN_ROWS:   window_rows_r <= cfg_data[mbs_pkg::WIN_W-1:0];
        mbs_pkg::CFG_WIN_COLS:   window_cols_r <= cfg_data[mbs_pkg::WIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    rows_eff = (frame_rows_r == '0) ? mbs_pkg::FROWS_W'(1) : frame_rows_r;
    if (frame_cols_r == '0) begin
      cols_eff = mbs_pkg::FCOLS_W'(1);
    end else if (frame_cols_r > mbs_pkg::FCOLS_W'(mbs_pkg::MAX_COLS)) begin
      cols_eff = mbs_pkg::FCOLS_W'(mbs_pkg::MAX_COLS);
    end else begin
      cols_eff = frame_cols_r;
    end

    win_ok = (window_rows_r != '0) &&
             (window_rows_r <= mbs_pkg::WIN_W'(mbs_pkg::MAX_WIN_ROWS)) &&
             (window_cols_r != '0) &&
             (window_cols_r <= mbs_pkg::WIN_W'(mbs_pkg::MAX_WIN_COLS));

    row_p1   = (mbs_pkg::FROWS_W+1)'(row_r) + (mbs_pkg::FROWS_W+1)'(1);
    col_ext  = mbs_pkg::FCOLS_W'(col_r);
    col_p1   = col_ext + mbs_pkg::FCOLS_W'(1);
    col_last = col_p1 >= cols_eff;
    row_last = row_p1 >= (mbs_pkg::FROWS_W+1)'(rows_eff);

    // slot of the row window_rows above, modulo the store depth
    old_sum = mbs_pkg::OS_W'(slot_r) + mbs_pkg::OS_W'(mbs_pkg::MAX_WIN_ROWS) -
              mbs_pkg::OS_W'(window_rows_r);
    if (old_sum >= mbs_pkg::OS_W'(mbs_pkg::MAX_WIN_ROWS)) begin
      rd_slot = mbs_pkg::SLOT_W'(old_sum - mbs_pkg::OS_W'(mbs_pkg::MAX_WIN_ROWS));
    end else begin
      rd_slot = mbs_pkg::SLOT_W'(old_sum);
    end

    flags.first_row = (row_r == '0);
    flags.sub_old   = row_r >= mbs_pkg::FROWS_W'(window_rows_r);
    flags.win_ok    = win_ok;
    flags.col0      = (col_r == '0);
    flags.sub_delay = col_ext >= mbs_pkg::FCOLS_W'(window_cols_r);
    flags.elig      = win_ok &&
                      (row_p1 >= (mbs_pkg::FROWS_W+1)'(window_rows_r)) &&
                      (col_p1 >= mbs_pkg::FCOLS_W'(window_cols_r));
    flags.last      = col_last && row_last;
    flags.tap       = mbs_pkg::TAP_W'(window_cols_r - mbs_pkg::WIN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (acc) begin
      if (col_last) begin
        col_r <= '0;
        if (row_last) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_p1[mbs_pkg::FROWS_W-1:0];
          slot_r <= (slot_r == mbs_pkg::SLOT_W'(mbs_pkg::MAX_WIN_ROWS - 1)) ?
                    '0 : slot_r + mbs_pkg::SLOT_W'(1);
        end
      end else begin
        col_r <= col_r + mbs_pkg::COL_W'(1);
      end
    end
  end

  mbs_colsum u_colsum (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .acc      (acc),
    .col      (col_r),
    .wr_slot  (slot_r),
    .rd_slot  (rd_slot),
    .sample   (in_sample),
    .flags_in (flags),
    .s2_valid (s2_valid),
    .s2_flags (s2_flags),
    .s2_cs    (s2_cs)
  );

  mbs_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .s2_valid     (s2_valid),
    .s2_flags     (s2_flags),
    .s2_cs        (s2_cs),
    .out_ready    (out_ready),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_best_sum (out_best_sum)
  );

endmodule

### src/mbs_cell.sv
// One cell of the column-sum delay chain.
// Depends on mbs_pkg.
module mbs_cell (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [mbs_pkg::CS_W-1:0]  d,
  output logic signed [mbs_pkg::CS_W-1:0]  q
);

  logic signed [mbs_pkg::CS_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

### src/mbs_colsum.sv
// Line store and column-sum memory; forms the vertical sum of each item.
// Depends on mbs_pkg.
module mbs_colsum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                acc,
  input  logic [mbs_pkg::COL_W-1:0]           col,
  input  logic [mbs_pkg::SLOT_W-1:0]          wr_slot,
  input  logic [mbs_pkg::SLOT_W-1:0]          rd_slot,
  input  logic signed [mbs_pkg::SAMPLE_W-1:0] sample,
  input  mbs_pkg::mbs_flags_t                 flags_in,
  output logic                                s2_valid,
  output mbs_pkg::mbs_flags_t                 s2_flags,
  output logic signed [mbs_pkg::CS_W-1:0]     s2_cs
);

  logic signed [mbs_pkg::SAMPLE_W-1:0] line_mem [mbs_pkg::LINE_DEPTH];
  logic signed [mbs_pkg::CS_W-1:0]     colsum_mem [mbs_pkg::MAX_COLS];

  logic signed [mbs_pkg::SAMPLE_W-1:0] old_rd_r;
  logic signed [mbs_pkg::CS_W-1:0]     cs_rd_r;

  logic                                s1_valid_r;
  mbs_pkg::mbs_flags_t                 s1_flags_r;
  logic [mbs_pkg::COL_W-1:0]           s1_col_r;
  logic signed [mbs_pkg::SAMPLE_W-1:0] s1_x_r;

  logic                                fwd_valid_r;
  logic [mbs_pkg::COL_W-1:0]           fwd_col_r;
  logic signed [mbs_pkg::CS_W-1:0]     fwd_cs_r;

  logic                                s2_valid_r;
  mbs_pkg::mbs_flags_t                 s2_flags_r;
  logic signed [mbs_pkg::CS_W-1:0]     s2_cs_r;

  logic signed [mbs_pkg::CS_W-1:0]     base;
  logic signed [mbs_pkg::CS_W-1:0]     old_ext;
  logic signed [mbs_pkg::CS_W-1:0]     x_ext;
  logic signed [mbs_pkg::CS_W-1:0]     cs_nxt;

  always_ff @(posedge clk) begin
    if (acc) begin
      line_mem[{wr_slot, col}] <= sample;
      old_rd_r                 <= line_mem[{rd_slot, col}];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cs_rd_r <= colsum_mem[col];
    end
    if (adv && s1_valid_r) begin
      colsum_mem[s1_col_r] <= cs_nxt;
    end
  end

  always_comb begin
    if (s1_flags_r.first_row) begin
      base = '0;
    end else if (fwd_valid_r && (fwd_col_r == s1_col_r)) begin
      base = fwd_cs_r;
    end else begin
      base = cs_rd_r;
    end
    x_ext   = {{(mbs_pkg::CS_W-mbs_pkg::SAMPLE_W){s1_x_r[mbs_pkg::SAMPLE_W-1]}}, s1_x_r};
    old_ext = s1_flags_r.sub_old ?
              {{(mbs_pkg::CS_W-mbs_pkg::SAMPLE_W){old_rd_r[mbs_pkg::SAMPLE_W-1]}}, old_rd_r} :
              '0;
    cs_nxt  = s1_flags_r.win_ok ? (base - old_ext + x_ext) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_flags_r <= flags_in;
      s1_col_r   <= col;
      s1_x_r     <= sample;
    end
    if (adv && s1_valid_r) begin
      fwd_col_r  <= s1_col_r;
      fwd_cs_r   <= cs_nxt;
      s2_flags_r <= s1_flags_r;
      s2_cs_r    <= cs_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_flags = s2_flags_r;
  assign s2_cs    = s2_cs_r;

endmodule

### src/mbs_window.sv
// Horizontal window sum over a chain of delay cells, best-sum tracking, result register.
// Depends on mbs_pkg and mbs_cell.
module mbs_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s2_valid,
  input  mbs_pkg::mbs_flags_t             s2_flags,
  input  logic signed [mbs_pkg::CS_W-1:0] s2_cs,
  input  logic                            out_ready,
  output logic                            adv,
  output logic                            out_valid,
  output logic [mbs_pkg::BEST_W-1:0]      out_best_sum
);

  logic signed [mbs_pkg::CS_W-1:0] dly_q [mbs_pkg::MAX_WIN_COLS];
  logic                            shift_en;

  logic signed [mbs_pkg::WS_W-1:0] ws_r;
  logic signed [mbs_pkg::WS_W-1:0] ws_nxt;
  logic signed [mbs_pkg::WS_W-1:0] ws_base;
  logic signed [mbs_pkg::WS_W-1:0] tap_ext;
  logic signed [mbs_pkg::WS_W-1:0] cs_ext;

  logic                            s3_valid_r;
  logic                            s3_elig_r;
  logic                            s3_last_r;
  logic signed [mbs_pkg::WS_W-1:0] s3_ws_r;

  logic [mbs_pkg::BEST_W-1:0]      best_r;
  logic [mbs_pkg::BEST_W-1:0]      best_nxt;
  logic [mbs_pkg::BEST_W-1:0]      out_best_r;
  logic                            out_valid_r;

  assign shift_en = adv && s2_valid;

  for (genvar i = 0; i < mbs_pkg::MAX_WIN_COLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      mbs_cell u_cell (.clk(clk), .en(shift_en), .d(s2_cs), .q(dly_q[i]));
    end else begin : g_body
      mbs_cell u_cell (.clk(clk), .en(shift_en), .d(dly_q[i-1]), .q(dly_q[i]));
    end
  end

  always_comb begin
    ws_base = s2_flags.col0 ? '0 : ws_r;
    cs_ext  = {{(mbs_pkg::WS_W-mbs_pkg::CS_W){s2_cs[mbs_pkg::CS_W-1]}}, s2_cs};
    tap_ext = s2_flags.sub_delay ?
              {{(mbs_pkg::WS_W-mbs_pkg::CS_W){dly_q[s2_flags.tap][mbs_pkg::CS_W-1]}},
               dly_q[s2_flags.tap]} :
              '0;
    ws_nxt  = s2_flags.win_ok ? (ws_base - tap_ext + cs_ext) : '0;
  end

  always_comb begin
    if (s3_elig_r && ($signed(s3_ws_r) > $signed({1'b0, best_r}))) begin
      best_nxt = s3_ws_r[mbs_pkg::BEST_W-1:0];
    end else begin
      best_nxt = best_r;
    end
  end

  // hold the pipe only while a frame result waits and another one is ready to leave
  assign adv = !(out_valid_r && !out_ready && s3_valid_r && s3_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= '0;
      s3_valid_r  <= 1'b0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (shift_en) begin
        ws_r <= ws_nxt;
      end
      if (adv) begin
        s3_valid_r <= s2_valid;
      end
      if (adv && s3_valid_r) begin
        best_r <= s3_last_r ? '0 : best_nxt;
      end
      if (adv && s3_valid_r && s3_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      s3_elig_r <= s2_flags.elig;
      s3_last_r <= s2_flags.last;
      s3_ws_r   <= ws_nxt;
    end
    if (adv && s3_valid_r && s3_last_r) begin
      out_best_r <= best_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_best_sum = out_best_r;

endmodule

### src/mbs_checker.sv
// Port-level checker for max_box_sum_2d_top, bound to the top level.
// Depends on mbs_pkg and max_box_sum_2d_top_macros.svh.
`include "max_box_sum_2d_top_macros.svh"

module mbs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [mbs_pkg::BEST_W-1:0]          out_best_sum
);

  `MBS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_best_sum), "result changed before transfer")
  `MBS_ASSERT(a_best_range, clk, rst_n, out_valid |-> out_best_sum <= 23'd8388352, "best sum out of range")
  `MBS_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled without a waiting result")
  `MBS_ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind max_box_sum_2d_top mbs_checker u_mbs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_best_sum (out_best_sum)
);

### test/max_box_sum_2d_chk.sv
// Watches the in, out and cfg channels of max_box_sum_2d_top, predicts the
// best window sum of each frame and compares it with every out transfer.
// Depends on mbs_pkg.
module max_box_sum_2d_chk (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [mbs_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [mbs_pkg::BEST_W-1:0]          out_best_sum,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [mbs_pkg::CFG_W-1:0]           cfg_data,
  output int                                  fails,
  output int                                  open_frames
);
  import mbs_pkg::*;

  logic [FROWS_W-1:0] frame_rows;
  logic [FCOLS_W-1:0] frame_cols;
  logic [WIN_W-1:0]   win_rows;
  logic [WIN_W-1:0]   win_cols;

  logic signed [SAMPLE_W-1:0] line_mem [MAX_WIN_ROWS][MAX_COLS];
  logic signed [CS_W-1:0]     col_sum [MAX_COLS];
  logic signed [CS_W-1:0]     cs_tap [MAX_WIN_COLS];
  logic signed [WS_W-1:0]     run_sum;
  logic [BEST_W-1:0]          best;
  int                         row_pos;
  int                         col_pos;

  logic [BEST_W-1:0] best_q [$];
  logic [BEST_W-1:0] want;

  initial begin
    fails = 0;
    open_frames = 0;
  end

  task automatic clear_frame();
    foreach (cs_tap[k]) cs_tap[k] = '0;
    run_sum = '0;
    best = '0;
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] x);
    int rows_eff, cols_eff, r, c, wr, wc;
    logic win_ok;
    logic signed [CS_W-1:0] cs;
    rows_eff = (frame_rows == 0) ? 1 : int'(frame_rows);
    cols_eff = (frame_cols == 0) ? 1 : int'(frame_cols);
    if (cols_eff > MAX_COLS) cols_eff = MAX_COLS;
    r = row_pos;
    c = col_pos;
    wr = int'(win_rows);
    wc = int'(win_cols);
    win_ok = wr >= 1 && wr <= MAX_WIN_ROWS && wc >= 1 && wc <= MAX_WIN_COLS;
    if (win_ok) begin
      cs = (r == 0) ? '0 : col_sum[c];
      if (r >= wr) cs = cs - line_mem[(r - wr) % MAX_WIN_ROWS][c];
      cs = cs + x;
      col_sum[c] = cs;
      if (c == 0) run_sum = '0;
      if (c >= wc) run_sum = run_sum - cs_tap[(c - wc) % MAX_WIN_COLS];
      run_sum = run_sum + cs;
      cs_tap[c % MAX_WIN_COLS] = cs;
      if (r + 1 >= wr && c + 1 >= wc && run_sum > $signed({1'b0, best}))
        best = run_sum[BEST_W-1:0];
    end else begin
      col_sum[c] = '0;
      run_sum = '0;
    end
    line_mem[r % MAX_WIN_ROWS][c] = x;
    if (c + 1 >= cols_eff) begin
      if (r + 1 >= rows_eff) begin
        best_q.push_back(best);
        clear_frame();
      end else begin
        col_pos = 0;
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_rows = 8;
      frame_cols = 8;
      win_rows = 2;
      win_cols = 2;
      clear_frame();
      best_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (best_q.size() == 0) begin
          fails++;
          $display("%0t unexpected transfer: expected none, got best_sum %0d",
                   $time, out_best_sum);
        end else begin
          want = best_q.pop_front();
          if (out_best_sum !== want) begin
            fails++;
            $display("%0t best_sum mismatch: expected %0d, got %0d",
                     $time, want, out_best_sum);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRAME_ROWS: frame_rows = cfg_data[FROWS_W-1:0];
          CFG_FRAME_COLS: frame_cols = cfg_data[FCOLS_W-1:0];
          CFG_WIN_ROWS:   win_rows = cfg_data[WIN_W-1:0];
          CFG_WIN_COLS:   win_cols = cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) absorb_sample(in_sample);
    end
    open_frames = best_q.size();
  end

endmodule

### test/tb.sv
// Stimulus and verdict for max_box_sum_2d_top: config phases, sample frames
// with random gaps and receiver stalls. Depends on mbs_pkg and max_box_sum_2d_chk.
module tb;
  import mbs_pkg::*;

  localparam int HALF         = 6;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN        = 8;
  localparam int CHOKE_CYCLES = 300;
  localparam int RAND_ITEMS   = 800;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic [BEST_W-1:0]          out_best_sum;
  logic                       cfg_valid;
  logic                       cfg_ready;
  cfg_idx_t                   cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  int fails;
  int open_frames;
  bit tx_quiet;
  bit rx_quiet;
  bit choke_req;
  int rows_set;
  int cols_set;

  max_box_sum_2d_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_best_sum (out_best_sum),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  max_box_sum_2d_chk i_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_best_sum (out_best_sum),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fails        (fails),
    .open_frames  (open_frames)
  );

  initial clk = 1'b0;
  always #HALF clk = ~clk;

  initial begin
    #(LIMIT_CYCLES * 2 * HALF);
    $display("tb failed");
    $finish;
  end

  function automatic int frame_len();
    int r, c;
    r = (rows_set == 0) ? 1 : rows_set;
    c = (cols_set == 0) ? 1 : cols_set;
    if (c > MAX_COLS) c = MAX_COLS;
    return r * c;
  endfunction

  // upper bits above the register width are don't-care
  function automatic logic [CFG_W-1:0] with_junk(input int val, input int w);
    logic [CFG_W-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom) : '0;
    return CFG_W'(val) | (junk << w);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: v = 32767;
      1: v = -32768;
      2, 3: v = $urandom;
      default: v = $urandom_range(0, 12000) - 3000;
    endcase
    return SAMPLE_W'(v);
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (idx == CFG_FRAME_ROWS) rows_set = int'(val[FROWS_W-1:0]);
    if (idx == CFG_FRAME_COLS) cols_set = int'(val[FCOLS_W-1:0]);
  endtask

  task automatic set_shape(input int rows, input int cols, input int wr, input int wc);
    while (open_frames != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    write_reg(CFG_FRAME_ROWS, CFG_W'(rows));
    write_reg(CFG_FRAME_COLS, with_junk(cols, FCOLS_W));
    write_reg(CFG_WIN_ROWS, with_junk(wr, WIN_W));
    write_reg(CFG_WIN_COLS, with_junk(wc, WIN_W));
    cfg_valid = 1'b0;
  endtask

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] v);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_frames(input int n);
    repeat (n * frame_len()) push_sample(pick_sample());
  endtask

  // receiver: random hold before each result transfer, one long choke on request
  initial begin : rx
    int hold;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (choke_req) begin
        out_ready = 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
        choke_req = 1'b0;
      end
      hold = rx_quiet ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stim
    int sent, r, c, er, ec, wr, wc, n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_ROWS;
    cfg_data = '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    choke_req = 1'b0;
    rows_set = 8;
    cols_set = 8;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset configuration: 8x8 frame, 2x2 window
    send_frames(1);

    // zero rows and cols act as a 1x1 frame; sample extremes
    set_shape(0, 0, 1, 1);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sd0);
    push_sample(16'sd1);
    set_shape(2, 2, 2, 2);
    repeat (4) push_sample(16'sh7FFF);
    set_shape(2, 3, 2, 2);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(-16'sd1);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    // bad window sizes
    set_shape(1, 1, 0, 1);
    push_sample(16'sh7FFF);
    set_shape(1, 1, 17, 1);
    push_sample(16'sh7FFF);
    set_shape(1, 1, 1, 0);
    push_sample(16'sh7FFF);
    set_shape(1, 1, 1, 31);
    push_sample(16'sh7FFF);
    // window larger than frame
    set_shape(2, 1, 3, 1);
    push_sample(16'sd100);
    push_sample(16'sd200);
    set_shape(1, 3, 1, 4);
    repeat (3) push_sample(16'sh7FFF);

    // tallest window past the row store wrap, then a single-column frame, no gaps
    tx_quiet = 1'b1;
    set_shape(19, 3, 16, 2);
    send_frames(1);
    set_shape(20, 1, 16, 1);
    send_frames(1);

    // long receiver stall with 1x1 frames so the block backs up
    set_shape(1, 1, 1, 1);
    choke_req = 1'b1;
    send_frames(40);
    tx_quiet = 1'b0;

    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: r = 0;
        1: r = $urandom_range(9, 40);
        default: r = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: c = 0;
        1: c = $urandom_range(9, 48);
        default: c = $urandom_range(1, 12);
      endcase
      ec = (c == 0) ? 1 : c;
      while (((r == 0) ? 1 : r) * ec > 160) r = r / 2;
      er = (r == 0) ? 1 : r;
      case ($urandom_range(0, 9))
        0: wr = $urandom_range(0, 31);
        1: wr = MAX_WIN_ROWS;
        default: wr = $urandom_range(1, (er < MAX_WIN_ROWS) ? er : MAX_WIN_ROWS);
      endcase
      case ($urandom_range(0, 9))
        0: wc = $urandom_range(0, 31);
        1: wc = MAX_WIN_COLS;
        default: wc = $urandom_range(1, (ec < MAX_WIN_COLS) ? ec : MAX_WIN_COLS);
      endcase
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      set_shape(r, c, wr, wc);
      n = $urandom_range(1, 3);
      send_frames(n);
      sent += n * frame_len();
    end
    in_valid = 1'b0;

    while (open_frames != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fails == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/mbs_pkg.sv
src/mbs_cell.sv
src/mbs_colsum.sv
src/mbs_window.sv
src/max_box_sum_2d_top.sv
src/mbs_checker.sv
test/max_box_sum_2d_chk.sv
test/tb.sv
